// ----- hw/rtl/acsd_pkg.sv -----
// Package for the ADC channel smoother: field widths, item types, register
// codes and the depth of the result queue. No dependencies.
`default_nettype none

package acsd_pkg;

  localparam int unsigned ChanW       = 6;
  localparam int unsigned SmpW        = 12;
  localparam int unsigned ScaledW     = 16;
  localparam int unsigned EnableW     = 64;
  localparam int unsigned CfgDataW    = 64;
  localparam int unsigned NumW        = SmpW + ScaledW;
  localparam int unsigned QuotW       = ScaledW + 1;
  localparam int unsigned QueueDepth  = 8;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned QueueCountW = $clog2(QueueDepth + 1);

  typedef enum logic {
    REG_CHANNEL_ENABLE = 1'b0,
    REG_DEADBAND       = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_CLEAR  = 1'b1
  } item_kind_e;

  typedef struct packed {
    item_kind_e        kind;
    logic [ChanW-1:0]  channel;
    logic [SmpW-1:0]   raw_sample;
    logic              force_refresh;
  } in_item_t;

  typedef struct packed {
    logic [ChanW-1:0]   out_channel;
    logic [ScaledW-1:0] scaled_value;
    logic [SmpW-1:0]    smoothed_value;
  } out_item_t;

  // A report leaving the update stage on its way to the scaler.
  typedef struct packed {
    logic              valid;
    logic [ChanW-1:0]  channel;
    logic [SmpW-1:0]   value;
  } report_t;

endpackage

`default_nettype wire

// ----- hw/rtl/acsd_if.sv -----
// Handshake interfaces of the ADC channel smoother: sample input, report
// output and configuration write channel. Depends on acsd_pkg.
`default_nettype none

interface acsd_in_if;
  logic               valid;
  logic               ready;
  acsd_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface acsd_out_if;
  logic                valid;
  logic                ready;
  acsd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface acsd_cfg_if;
  logic                                valid;
  logic                                ready;
  acsd_pkg::cfg_reg_e                  index;
  logic [acsd_pkg::CfgDataW-1:0]       data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/acsd_update.sv -----
// Per-channel state memory and read-modify-write update of the smoother.
// Holds seed flags, averages and last reported values. Depends on acsd_pkg.
`default_nettype none

module acsd_update #(
  parameter int unsigned CHANNELS    = 64,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  acsd_pkg::in_item_t            item_i,
  input  logic [acsd_pkg::EnableW-1:0]  enable_i,
  input  logic [acsd_pkg::SmpW-1:0]     deadband_i,
  output acsd_pkg::report_t             report_o,
  output logic [1:0]                    busy_o
);
  import acsd_pkg::*;

  localparam int unsigned IdxW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned FullScale = (1 << SAMPLE_BITS) - 1;
  localparam logic [SmpW-1:0] SatLimit =
    (FullScale >= 4095) ? {SmpW{1'b1}} : SmpW'(FullScale);
  localparam int unsigned EntryW = 2 * SmpW;

  // Each entry holds {average, last reported value}.
  logic [EntryW-1:0] state_mem [CHANNELS];
  logic [EntryW-1:0] rd_data_q;

  logic              p1_valid_q;
  in_item_t          p1_item_q;

  logic              fwd_valid_q;
  logic [IdxW-1:0]   fwd_idx_q;
  logic [EntryW-1:0] fwd_data_q;

  logic [CHANNELS-1:0] seeded_q, seeded_d;
  report_t             report_q, report_d;

  logic [IdxW-1:0]   rd_idx, ch_idx;
  logic              in_range, is_sample, is_clear, was_seeded, hit;
  logic [EntryW-1:0] old_entry, wr_data;
  logic [SmpW-1:0]   old_avg, old_last, raw_sat, new_avg, move_abs;
  logic signed [SmpW+1:0] step, rounded, delta, sum;

  assign rd_idx = item_i.channel[IdxW-1:0];
  assign ch_idx = p1_item_q.channel[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    rd_data_q <= state_mem[rd_idx];
    if (is_sample) begin
      state_mem[ch_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
      seeded_q    <= '0;
      report_q    <= '0;
    end else begin
      p1_valid_q  <= accept_i;
      fwd_valid_q <= is_sample;
      seeded_q    <= seeded_d;
      report_q    <= report_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      p1_item_q <= item_i;
    end
    fwd_idx_q  <= ch_idx;
    fwd_data_q <= wr_data;
  end

  always_comb begin
    in_range   = (32'(p1_item_q.channel) < CHANNELS);
    is_clear   = p1_valid_q && (p1_item_q.kind == KIND_CLEAR);
    is_sample  = p1_valid_q && (p1_item_q.kind == KIND_SAMPLE) && in_range &&
                 enable_i[p1_item_q.channel];
    was_seeded = seeded_q[ch_idx];

    // The entry written at the edge that issued our read is not yet in rd_data_q.
    old_entry = (fwd_valid_q && (fwd_idx_q == ch_idx)) ? fwd_data_q : rd_data_q;
    old_avg   = old_entry[EntryW-1:SmpW];
    old_last  = old_entry[SmpW-1:0];

    raw_sat = (p1_item_q.raw_sample > SatLimit) ? SatLimit : p1_item_q.raw_sample;

    // One eighth of the step, offset by four away from zero, then floored by the shift.
    step    = $signed({2'b00, raw_sat}) - $signed({2'b00, old_avg});
    rounded = step[SmpW+1] ? (step - (SmpW+2)'(4)) : (step + (SmpW+2)'(4));
    delta   = rounded >>> 3;
    sum     = $signed({2'b00, old_avg}) + delta;

    if (sum[SmpW+1]) begin
      new_avg = '0;
    end else if (sum > $signed({2'b00, SatLimit})) begin
      new_avg = SatLimit;
    end else begin
      new_avg = sum[SmpW-1:0];
    end

    move_abs = (new_avg >= old_last) ? (new_avg - old_last) : (old_last - new_avg);
    hit      = p1_item_q.force_refresh || (move_abs >= deadband_i);

    if (was_seeded) begin
      wr_data = {new_avg, hit ? new_avg : old_last};
    end else begin
      wr_data = {raw_sat, raw_sat};
    end

    seeded_d = seeded_q;
    if (is_clear) begin
      seeded_d = '0;
    end else if (is_sample) begin
      seeded_d[ch_idx] = 1'b1;
    end

    report_d.valid   = is_sample && was_seeded && hit;
    report_d.channel = p1_item_q.channel;
    report_d.value   = new_avg;
  end

  assign report_o = report_q;
  assign busy_o   = 2'(p1_valid_q) + 2'(report_q.valid);

endmodule

`default_nettype wire

// ----- hw/rtl/acsd_scale.sv -----
// Scaler of the smoother: average * 65535 / full scale, rounded half up,
// by reciprocal multiplication and one correction step. Depends on acsd_pkg.
`default_nettype none

module acsd_scale #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  acsd_pkg::report_t   report_i,
  output logic                push_o,
  output acsd_pkg::out_item_t push_data_o,
  output logic [1:0]          busy_o
);
  import acsd_pkg::*;

  localparam int unsigned FullScale = (1 << SAMPLE_BITS) - 1;
  localparam int unsigned RecipW    = 33 - SAMPLE_BITS;
  localparam int unsigned ProdW     = NumW + RecipW;
  localparam logic [RecipW-1:0] Recip   = RecipW'((64'd1 << 32) / FullScale);
  localparam logic [NumW-1:0]   Half    = NumW'(FullScale / 2);
  localparam logic [QuotW-1:0]  FsQuot  = QuotW'(FullScale);
  localparam logic [NumW-1:0]   FsNum   = NumW'(FullScale);

  logic               a_valid_q, b_valid_q, c_valid_q;
  logic [ChanW-1:0]   a_ch_q, b_ch_q, c_ch_q;
  logic [SmpW-1:0]    a_avg_q, b_avg_q, c_avg_q;
  logic [NumW-1:0]    a_num_q, b_num_q, c_num_q;
  logic [QuotW-1:0]   b_quot_q, c_quot_q;
  logic [2*QuotW-1:0] c_back_q;

  logic [NumW-1:0]  num_d, rem;
  logic [ProdW-1:0] prod;
  logic [QuotW-1:0] quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      a_valid_q <= report_i.valid;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
    end
  end

  // avg * 65535 is taken as avg * 65536 - avg.
  assign num_d = NumW'({report_i.value, {ScaledW{1'b0}}}) - NumW'(report_i.value) + Half;
  assign prod  = a_num_q * Recip;

  always_ff @(posedge clk_i) begin
    a_ch_q   <= report_i.channel;
    a_avg_q  <= report_i.value;
    a_num_q  <= num_d;
    b_ch_q   <= a_ch_q;
    b_avg_q  <= a_avg_q;
    b_num_q  <= a_num_q;
    b_quot_q <= QuotW'(prod >> 32);
    c_ch_q   <= b_ch_q;
    c_avg_q  <= b_avg_q;
    c_num_q  <= b_num_q;
    c_quot_q <= b_quot_q;
    c_back_q <= b_quot_q * FsQuot;
  end

  // The estimate is the true quotient or one below it.
  always_comb begin
    rem  = c_num_q - NumW'(c_back_q);
    quot = (rem >= FsNum) ? (c_quot_q + QuotW'(1)) : c_quot_q;
    push_data_o.out_channel    = c_ch_q;
    push_data_o.scaled_value   = quot[ScaledW-1:0];
    push_data_o.smoothed_value = c_avg_q;
  end

  assign push_o = c_valid_q;
  assign busy_o = 2'(a_valid_q) + 2'(b_valid_q) + 2'(c_valid_q);

endmodule

`default_nettype wire

// ----- hw/rtl/acsd_fifo.sv -----
// Result queue of the smoother, parting the pipeline from the output
// handshake. Entries are reserved in advance by the top level. Depends on acsd_pkg.
`default_nettype none

module acsd_fifo (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  input  acsd_pkg::out_item_t               push_data_i,
  input  logic                              pop_i,
  output logic                              valid_o,
  output acsd_pkg::out_item_t               data_o,
  output logic [acsd_pkg::QueueCountW-1:0]  count_o
);
  import acsd_pkg::*;

  out_item_t              entry_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QueueCountW-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? (wr_ptr_q + QueuePtrW'(1)) : wr_ptr_q;
    rd_ptr_d = pop_i  ? (rd_ptr_q + QueuePtrW'(1)) : rd_ptr_q;
    count_d  = count_q + QueueCountW'(push_i) - QueueCountW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];
  assign count_o = count_q;

endmodule

`default_nettype wire

// ----- hw/rtl/adc_channel_smoother_deadband.sv -----
// A report passes the p1 register, the report register, scaler stages a, b and c
// and the result queue. Throughput: one item per cycle; acceptance is limited
// only by the eight-entry result queue, whose free places are reserved for items
// still in the pipeline. State read-modify-write uses a single-port read memory
// with forwarding of the previous write. Reset clears seed flags, registers to
// their defaults (enable 0, deadband 8) and the queue; averages are not cleared.
`default_nettype none

module adc_channel_smoother_deadband #(
  parameter int unsigned CHANNELS    = 64,
  parameter int unsigned SAMPLE_BITS = 12
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  acsd_in_if.sink      sample_i,
  acsd_out_if.source   report_o,
  acsd_cfg_if.sink     cfg_i
);
  import acsd_pkg::*;

  localparam int unsigned CreditW = QueueCountW + 1;

  logic [EnableW-1:0]     enable_q;
  logic [SmpW-1:0]        deadband_q;
  logic                   accept;
  report_t                report;
  logic [1:0]             busy_upd, busy_scl;
  logic                   push;
  out_item_t              push_data;
  logic [QueueCountW-1:0] queue_count;
  logic [CreditW-1:0]     committed;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q   <= '0;
      deadband_q <= SmpW'(8);
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_CHANNEL_ENABLE: enable_q   <= cfg_i.data;
        REG_DEADBAND:       deadband_q <= cfg_i.data[SmpW-1:0];
        default: ;
      endcase
    end
  end

  // Every item in flight may still need a queue place.
  assign committed      = CreditW'(queue_count) + CreditW'(busy_upd) + CreditW'(busy_scl);
  assign sample_i.ready = (committed < CreditW'(QueueDepth));
  assign accept         = sample_i.valid && sample_i.ready;

  acsd_update #(
    .CHANNELS    (CHANNELS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .item_i     (sample_i.data),
    .enable_i   (enable_q),
    .deadband_i (deadband_q),
    .report_o   (report),
    .busy_o     (busy_upd)
  );

  acsd_scale #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .report_i    (report),
    .push_o      (push),
    .push_data_o (push_data),
    .busy_o      (busy_scl)
  );

  acsd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (report_o.valid && report_o.ready),
    .valid_o     (report_o.valid),
    .data_o      (report_o.data),
    .count_o     (queue_count)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/acsd_checker.sv -----
// Port-level checks of the ADC channel smoother and their binding to the
// top level. Depends on adc_channel_smoother_deadband.
`default_nettype none

module acsd_checker #(
  parameter int unsigned SAMPLE_BITS = 12
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [33:0] out_payload_i,
  input logic [15:0] out_scaled_i,
  input logic [11:0] out_smoothed_i
);

  localparam bit CheckScale = (SAMPLE_BITS == 12);

  logic seen_in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_in_q <= 1'b0;
    end else if (in_valid_i && in_ready_i) begin
      seen_in_q <= 1'b1;
    end
  end

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("report withdrawn before its transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_payload_i))
    else $error("report payload changed while stalled");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seen_in_q)
    else $error("report offered before any sample transfer");

  a_scale_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && CheckScale |-> (out_scaled_i[15:4] == out_smoothed_i))
    else $error("scaled value disagrees with smoothed value");

endmodule

bind adc_channel_smoother_deadband acsd_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_acsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (sample_i.valid),
  .in_ready_i     (sample_i.ready),
  .out_valid_i    (report_o.valid),
  .out_ready_i    (report_o.ready),
  .out_payload_i  (report_o.data),
  .out_scaled_i   (report_o.data.scaled_value),
  .out_smoothed_i (report_o.data.smoothed_value)
);

`default_nettype wire

// ----- sim/tb_adc_channel_smoother_deadband.sv -----
// Self-checking testbench for adc_channel_smoother_deadband: a directed opening, then random
// sample and clear traffic under several enable masks, deadbands and idling patterns.
// Depends on acsd_pkg, the acsd interfaces and the block itself.
`default_nettype none

module tb_adc_channel_smoother_deadband;
  timeunit 1ns;
  timeprecision 1ps;

  import acsd_pkg::*;

  localparam int unsigned FullScale   = 4095;
  localparam int unsigned DrainCycles = 12;

  logic clk_i = 1'b0;
  logic rst_ni;

  acsd_in_if  sample_if ();
  acsd_out_if report_if ();
  acsd_cfg_if cfg_if ();

  adc_channel_smoother_deadband u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .report_o (report_if),
    .cfg_i    (cfg_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow of the block's registers and per-channel state.
  logic [EnableW-1:0] en_mask;
  logic [SmpW-1:0]    deadband_thr;
  logic [63:0]        chan_seeded;
  logic [SmpW-1:0]    chan_avg  [64];
  logic [SmpW-1:0]    chan_last [64];

  in_item_t  sample_backlog [$];
  out_item_t pending_reports [$];
  int        target_level [64];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned error_count;

  task automatic note_error(string msg);
    $display("%0t ns: %s", $realtime, msg);
    error_count++;
  endtask

  // Applies one accepted item to the shadow state and queues the report it causes.
  function automatic void update_channel_average(in_item_t it);
    int        step;
    int        avg_n;
    int        diff;
    out_item_t rep;
    if (it.kind == KIND_CLEAR) begin
      chan_seeded = '0;
      return;
    end
    if (!en_mask[it.channel]) return;
    if (!chan_seeded[it.channel]) begin
      chan_seeded[it.channel] = 1'b1;
      chan_avg[it.channel]    = it.raw_sample;
      chan_last[it.channel]   = it.raw_sample;
      return;
    end
    step = int'(it.raw_sample) - int'(chan_avg[it.channel]);
    step = (step >= 0) ? step + 4 : step - 4;
    // An arithmetic shift of a signed int rounds towards minus infinity.
    avg_n = int'(chan_avg[it.channel]) + (step >>> 3);
    if (avg_n < 0) avg_n = 0;
    if (avg_n > int'(FullScale)) avg_n = FullScale;
    chan_avg[it.channel] = avg_n[SmpW-1:0];
    diff = avg_n - int'(chan_last[it.channel]);
    if (diff < 0) diff = -diff;
    if (!it.force_refresh && diff < int'(deadband_thr)) return;
    chan_last[it.channel] = avg_n[SmpW-1:0];
    rep.out_channel    = it.channel;
    rep.scaled_value   = ScaledW'((avg_n * 65535 + int'(FullScale / 2)) / int'(FullScale));
    rep.smoothed_value = avg_n[SmpW-1:0];
    pending_reports.push_back(rep);
  endfunction

  // Sample driver: holds an offered item until its transfer, then offers the next one.
  always @(posedge clk_i) begin
    if (rst_ni && sample_if.valid && sample_if.ready) begin
      update_channel_average(sample_if.data);
    end
    if (!sample_if.valid || sample_if.ready) begin
      if (rst_ni && sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        sample_if.valid <= 1'b1;
        sample_if.data  <= sample_backlog.pop_front();
      end else begin
        sample_if.valid <= 1'b0;
      end
    end
  end

  // Report monitor with random back-pressure.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && report_if.valid && report_if.ready) begin
      if (pending_reports.size() == 0) begin
        note_error($sformatf("unexpected report: channel %0d value %0d",
                             report_if.data.out_channel, report_if.data.smoothed_value));
      end else begin
        want = pending_reports.pop_front();
        if (report_if.data.out_channel !== want.out_channel)
          note_error($sformatf("out_channel got %0d expected %0d",
                               report_if.data.out_channel, want.out_channel));
        if (report_if.data.scaled_value !== want.scaled_value)
          note_error($sformatf("scaled_value got %0d expected %0d on channel %0d",
                               report_if.data.scaled_value, want.scaled_value,
                               want.out_channel));
        if (report_if.data.smoothed_value !== want.smoothed_value)
          note_error($sformatf("smoothed_value got %0d expected %0d on channel %0d",
                               report_if.data.smoothed_value, want.smoothed_value,
                               want.out_channel));
      end
    end
    report_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic write_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == REG_CHANNEL_ENABLE) en_mask = val;
    else deadband_thr = val[SmpW-1:0];
  endtask

  // Waits at falling edges until every item has been transferred and every report seen.
  task automatic wait_quiet(int unsigned max_cycles);
    int unsigned n;
    n = 0;
    do begin
      @(negedge clk_i);
      n++;
    end while ((sample_backlog.size() != 0 || sample_if.valid || pending_reports.size() != 0)
               && n < max_cycles);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic push_sample(int unsigned ch, int unsigned raw, bit frc);
    in_item_t it;
    it.kind          = KIND_SAMPLE;
    it.channel       = ch[ChanW-1:0];
    it.raw_sample    = raw[SmpW-1:0];
    it.force_refresh = frc;
    sample_backlog.push_back(it);
  endtask

  task automatic push_clear(int unsigned ch, int unsigned raw, bit frc);
    in_item_t it;
    it.kind          = KIND_CLEAR;
    it.channel       = ch[ChanW-1:0];
    it.raw_sample    = raw[SmpW-1:0];
    it.force_refresh = frc;
    sample_backlog.push_back(it);
  endtask

  // Mostly samples that wander around a per-channel level, so that the deadband decides;
  // the rest are jumps, extremes and occasional clears. Samples on disabled channels are
  // noise that the block must drop.
  task automatic queue_random_items(int unsigned n);
    int unsigned counted;
    int unsigned ch;
    int          raw;
    int unsigned hot [3];
    hot = '{0, 2, 62};
    counted = 0;
    while (counted < n) begin
      if ($urandom_range(59) == 0) begin
        push_clear($urandom_range(63), $urandom_range(FullScale), $urandom_range(1) == 1);
        counted++;
      end else begin
        ch = ($urandom_range(99) < 45) ? hot[$urandom_range(2)] : $urandom_range(63);
        if ($urandom_range(19) == 0) target_level[ch] = $urandom_range(FullScale);
        case ($urandom_range(9))
          0:       raw = $urandom_range(1) ? FullScale : 0;
          1, 2:    raw = $urandom_range(FullScale);
          default: raw = target_level[ch] + int'($urandom_range(48)) - 24;
        endcase
        if (raw < 0) raw = 0;
        if (raw > int'(FullScale)) raw = FullScale;
        push_sample(ch, raw, $urandom_range(9) == 0);
        counted++;
      end
    end
  endtask

  task automatic run_phase(logic [EnableW-1:0] mask, int unsigned db, int unsigned send_pct,
                           int unsigned recv_pct, int unsigned n);
    wait_quiet(200000);
    write_reg(REG_CHANNEL_ENABLE, mask);
    write_reg(REG_DEADBAND, CfgDataW'(db));
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    @(negedge clk_i);
    queue_random_items(n);
  endtask

  initial begin
    rst_ni          = 1'b0;
    sample_if.valid = 1'b0;
    sample_if.data  = '0;
    report_if.ready = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.index    = REG_CHANNEL_ENABLE;
    cfg_if.data     = '0;
    en_mask         = '0;
    deadband_thr    = 12'd8;
    chan_seeded     = '0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    error_count     = 0;
    for (int i = 0; i < 64; i++) begin
      chan_avg[i]     = '0;
      chan_last[i]    = '0;
      target_level[i] = $urandom_range(FullScale);
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // With every channel disabled, samples vanish.
    write_reg(REG_CHANNEL_ENABLE, '0);
    push_sample(0, 123, 1'b0);
    push_sample(63, FullScale, 1'b1);
    wait_quiet(200000);

    write_reg(REG_CHANNEL_ENABLE, ~64'h2);
    write_reg(REG_DEADBAND, CfgDataW'(8));
    @(negedge clk_i);
    push_sample(0, 0, 1'b0);             // seeds silently
    push_sample(0, FullScale, 1'b0);     // largest upward step
    push_sample(0, FullScale, 1'b1);
    push_sample(63, FullScale, 1'b0);
    push_sample(63, 0, 1'b0);            // largest downward step
    push_sample(63, 0, 1'b1);
    push_sample(1, 100, 1'b1);           // disabled channel
    push_sample(5, 2048, 1'b0);
    push_sample(5, 2049, 1'b0);          // a step of one is rounded away
    push_sample(5, 2047, 1'b0);          // a step of minus one still moves down
    push_sample(5, 2047, 1'b1);          // forced report below the deadband
    push_clear(63, FullScale, 1'b1);
    push_sample(0, FullScale, 1'b0);     // seeds again after the clear
    push_sample(0, FullScale, 1'b1);
    push_sample(63, 2000, 1'b0);
    push_sample(63, 2100, 1'b0);
    push_sample(63, 2100, 1'b0);
    push_clear(0, 0, 1'b0);
    push_sample(42, 4000, 1'b0);
    push_sample(42, 10, 1'b0);

    run_phase('1, 8, 0, 0, 300);
    run_phase({$urandom, $urandom} | 64'h4000_0000_0000_0005, 0, 66, 0, 250);
    run_phase({$urandom, $urandom} | 64'h4000_0000_0000_0005, FullScale, 0, 66, 250);
    // Disabling channels mid-run must keep their seeds and averages.
    run_phase('1, $urandom_range(1, 40), 23, 23, 300);
    run_phase(64'h5555_5555_5555_5555, 12, 0, 0, 450);

    wait_quiet(20000);
    if (pending_reports.size() != 0)
      note_error($sformatf("%0d expected reports never arrived", pending_reports.size()));
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
hw/rtl/acsd_pkg.sv
hw/rtl/acsd_if.sv
hw/rtl/acsd_update.sv
hw/rtl/acsd_scale.sv
hw/rtl/acsd_fifo.sv
hw/rtl/adc_channel_smoother_deadband.sv
hw/rtl/acsd_checker.sv
sim/tb_adc_channel_smoother_deadband.sv
